// File: rtl/printable_run_extractor_top_assert.svh
// Assertion macros for the printable run extractor.
// Included by the RTL top level, which carries the concurrent assertions; no other dependencies.
`ifndef PRINTABLE_RUN_EXTRACTOR_TOP_ASSERT_SVH
`define PRINTABLE_RUN_EXTRACTOR_TOP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define PRE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("printable run extractor: assertion failed");
`define PRE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("printable run extractor: assertion failed");
`else
`define PRE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PRE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: rtl/pre_pkg.sv
// Package for the printable run extractor: sizes, cell control type, helpers.
// No dependencies.
package pre_pkg;

  localparam int unsigned MaxMinLen = 64;
  localparam int unsigned IdxW      = $clog2(MaxMinLen);
  localparam int unsigned CntW      = 7;
  localparam int unsigned ByteW     = 8;

  localparam logic [CntW-1:0] RunReleased = CntW'(MaxMinLen + 1);
  localparam logic [CntW-1:0] ResetMinLen = CntW'(4);

  localparam logic [ByteW-1:0] ChTab   = 8'h09;
  localparam logic [ByteW-1:0] ChNl    = 8'h0A;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChTilde = 8'h7E;

  typedef struct packed {
    logic             shift;
    logic [ByteW-1:0] data;
  } cell_ctrl_t;

  function automatic logic is_printable(input logic [ByteW-1:0] b);
    return (b >= ChSpace && b <= ChTilde) || b == ChTab || b == ChNl;
  endfunction

  function automatic logic [CntW-1:0] eff_min(input logic [CntW-1:0] v);
    logic [CntW-1:0] r;
    if (v == '0) begin
      r = CntW'(1);
    end else if (v > CntW'(MaxMinLen)) begin
      r = CntW'(MaxMinLen);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// File: rtl/pre_if.sv
// Valid/ready channel interfaces for the printable run extractor.
// No dependencies.
interface pre_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface pre_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_start;
  logic       last;

  modport source (output valid, output out_byte, output run_start, output last, input ready);
  modport sink   (input valid, input out_byte, input run_start, input last, output ready);
endinterface

// File: rtl/pre_cell.sv
// One byte cell of the pending-run chain: loads a byte or takes its neighbour's.
// Depends on pre_pkg.
module pre_cell (
  input  logic                    clk_i,
  input  pre_pkg::cell_ctrl_t     ctrl_i,
  input  logic                    load_i,
  input  logic [pre_pkg::ByteW-1:0] next_i,
  output logic [pre_pkg::ByteW-1:0] byte_o
);
  import pre_pkg::*;

  logic [ByteW-1:0] byte_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      byte_q <= ctrl_i.data;
    end else if (ctrl_i.shift) begin
      byte_q <= next_i;
    end
  end

  assign byte_o = byte_q;

endmodule

// File: rtl/printable_run_extractor_top.sv
// Printable run extractor: a byte word in, held run flushed through a chain of cells.
// An accepted pass-through byte goes straight into the output register;
//   a releasing byte's burst starts in the cycle after it is accepted, its own word last.
// Throughput: one byte per cycle unless the output stalls; a releasing byte stalls input
//   for held count + 1 words, one per cycle unless stalled, from the cell chain head.
// Reset: asynchronous, active low; clears run count, burst state and output valid,
//   and sets the minimum run length to 4. Cell contents are not reset.
module printable_run_extractor_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [pre_pkg::CntW-1:0]   cfg_wdata_i,
  pre_in_if.sink                     in_i,
  pre_out_if.source                  out_o
);
  import pre_pkg::*;

  `include "printable_run_extractor_top_assert.svh"

  logic [CntW-1:0]  min_q;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  left_q, left_d;
  logic             first_q, first_d;
  logic             ov_q, ov_d;
  logic [ByteW-1:0] obyte_q, obyte_d;
  logic             ostart_q, ostart_d;
  logic             olast_q, olast_d;

  logic             out_free, acc, drop, rel, hold, wr, release_run, pass, step, oload;
  logic [IdxW-1:0]  cnt_idx;
  cell_ctrl_t       cell_ctrl;
  logic [ByteW-1:0] cell_byte [MaxMinLen];

  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (left_q == '0) && out_free;
  assign acc = in_i.valid && in_i.ready;
  assign drop = in_i.end_of_stream || !is_printable(in_i.data_byte);
  assign rel = (cnt_q == RunReleased);
  assign cnt_idx = cnt_q[IdxW-1:0];
  assign hold = (CntW'(cnt_idx) + CntW'(1)) < eff_min(min_q);
  assign wr = acc && !drop && !rel;
  assign release_run = wr && !hold;
  assign pass = acc && !drop && rel;
  assign step = (left_q != '0) && out_free;
  assign oload = pass || step;

  assign cell_ctrl.shift = step;
  assign cell_ctrl.data  = in_i.data_byte;

  for (genvar g = 0; g < MaxMinLen; g++) begin : g_cell
    logic [ByteW-1:0] nxt;
    if (g == MaxMinLen - 1) begin : g_tail
      assign nxt = cell_byte[g];
    end else begin : g_mid
      assign nxt = cell_byte[g+1];
    end
    pre_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl),
      .load_i (wr && (cnt_idx == IdxW'(g))),
      .next_i (nxt),
      .byte_o (cell_byte[g])
    );
  end

  always_comb begin
    cnt_d    = cnt_q;
    left_d   = left_q;
    first_d  = first_q;
    obyte_d  = obyte_q;
    ostart_d = ostart_q;
    olast_d  = olast_q;
    ov_d     = ov_q && !out_o.ready;
    if (acc) begin
      if (drop) begin
        cnt_d = '0;
      end else if (rel) begin
        obyte_d  = in_i.data_byte;
        ostart_d = 1'b0;
        olast_d  = 1'b1;
      end else if (hold) begin
        cnt_d = CntW'(cnt_idx) + CntW'(1);
      end else begin
        cnt_d   = RunReleased;
        left_d  = CntW'(cnt_idx) + CntW'(1);
        first_d = 1'b1;
      end
    end
    if (step) begin
      obyte_d  = cell_byte[0];
      ostart_d = first_q;
      olast_d  = (left_q == CntW'(1));
      left_d   = left_q - CntW'(1);
      first_d  = 1'b0;
    end
    if (oload) begin
      ov_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q   <= ResetMinLen;
      cnt_q   <= '0;
      left_q  <= '0;
      first_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        min_q <= cfg_wdata_i;
      end
      cnt_q   <= cnt_d;
      left_q  <= left_d;
      first_q <= first_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    obyte_q  <= obyte_d;
    ostart_q <= ostart_d;
    olast_q  <= olast_d;
  end

  assign out_o.valid     = ov_q;
  assign out_o.out_byte  = obyte_q;
  assign out_o.run_start = ostart_q;
  assign out_o.last      = olast_q;

  `PRE_ASSERT_NXT(a_release_starts_burst, clk_i, rst_ni, release_run,
                  left_q != '0 && first_q && cnt_q == RunReleased)
  `PRE_ASSERT_IMP(a_burst_only_released, clk_i, rst_ni, left_q != '0, cnt_q == RunReleased)
  `PRE_ASSERT_IMP(a_cnt_legal, clk_i, rst_ni, 1'b1,
                  cnt_q < CntW'(MaxMinLen) || cnt_q == RunReleased)
  `PRE_ASSERT_IMP(a_first_in_burst, clk_i, rst_ni, first_q, left_q != '0)

endmodule

// File: verif/printable_run_extractor_top_test.sv
// Self-checking testbench for printable_run_extractor_top: printable-run filtering over
// the valid/ready byte channels, predicted word by word by a small scoreboard class.
// Depends on pre_pkg, pre_in_if/pre_out_if and the RTL top level.
module printable_run_extractor_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import pre_pkg::*;

  typedef struct packed {
    logic [ByteW-1:0] ch;
    logic             start;
    logic             fin;
  } out_word_t;

  class run_scoreboard;
    logic [CntW-1:0]  min_len;
    int unsigned      run_len;
    logic [ByteW-1:0] held [MaxMinLen];
    out_word_t        words_q [$];
    int               errors;

    function new();
      min_len = ResetMinLen;
      run_len = 0;
      errors  = 0;
    endfunction

    static function bit is_text(logic [ByteW-1:0] b);
      return (b >= 8'h20 && b <= 8'h7E) || b == ChTab || b == ChNl;
    endfunction

    function int unsigned eff_min();
      if (min_len == 0) return 1;
      if (min_len > MaxMinLen) return MaxMinLen;
      return min_len;
    endfunction

    function void set_min(logic [CntW-1:0] v);
      min_len = v;
    endfunction

    function int backlog();
      return words_q.size();
    endfunction

    function void note_byte(logic [ByteW-1:0] b, logic eos);
      int unsigned m;
      if (eos || !is_text(b)) begin
        run_len = 0;
        return;
      end
      if (run_len == RunReleased) begin
        words_q.push_back('{b, 1'b0, 1'b1});
        return;
      end
      m = eff_min();
      if (run_len >= MaxMinLen) run_len = MaxMinLen - 1;
      if (run_len + 1 < m) begin
        held[run_len] = b;
        run_len++;
        return;
      end
      for (int unsigned i = 0; i < run_len; i++) begin
        words_q.push_back('{held[i], i == 0, 1'b0});
      end
      words_q.push_back('{b, run_len == 0, 1'b1});
      run_len = RunReleased;
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      if (words_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, got %h/%b/%b",
                 $time, got.ch, got.start, got.fin);
        errors++;
        return;
      end
      want = words_q.pop_front();
      if (got.ch !== want.ch) begin
        $display("%0t: out_byte expected %h got %h", $time, want.ch, got.ch);
        errors++;
      end
      if (got.start !== want.start) begin
        $display("%0t: run_start expected %b got %b", $time, want.start, got.start);
        errors++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: last expected %b got %b", $time, want.fin, got.fin);
        errors++;
      end
    endfunction
  endclass

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we;
  logic [CntW-1:0] cfg_wdata;

  pre_in_if  in_ch ();
  pre_out_if out_ch ();

  run_scoreboard sb;
  int            idle_pct = 28;
  int            bytes_sent = 0;

  printable_run_extractor_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic send_word(input logic [ByteW-1:0] b, input logic eos);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.data_byte     <= b;
    in_ch.end_of_stream <= eos;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_byte(b, eos);
    bytes_sent++;
  endtask

  function automatic logic [ByteW-1:0] pick_text();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return ChTab;
    if (r == 1) return ChNl;
    return 8'($urandom_range(8'h20, 8'h7E));
  endfunction

  function automatic logic [ByteW-1:0] pick_noise();
    logic [ByteW-1:0] b;
    do b = 8'($urandom_range(255)); while (run_scoreboard::is_text(b));
    return b;
  endfunction

  // one printable run of random length, then a random terminator (or none)
  task automatic send_run();
    int unsigned len;
    int unsigned t;
    if ($urandom_range(9) == 0) len = $urandom_range(0, 70);
    else len = $urandom_range(0, sb.eff_min() + 3);
    repeat (len) send_word(pick_text(), 1'b0);
    t = $urandom_range(7);
    if (t <= 2) send_word(8'($urandom_range(255)), 1'b1);
    else if (t <= 6) send_word(pick_noise(), 1'b0);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.backlog() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_min(input logic [CntW-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.set_min(v);
  endtask

  initial begin : source_side
    logic [CntW-1:0] mins [8];
    int              budget;
    sb = new();
    rst_ni              <= 1'b0;
    cfg_we              <= 1'b0;
    cfg_wdata           <= '0;
    in_ch.valid         <= 1'b0;
    in_ch.data_byte     <= '0;
    in_ch.end_of_stream <= 1'b0;
    out_ch.ready        <= 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset minimum of four
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word("q", 1'b1);
    send_word("a", 1'b0);
    send_word("b", 1'b0);
    send_word("c", 1'b0);
    send_word(8'h1F, 1'b0);
    send_word(8'h20, 1'b0);
    send_word(8'h7E, 1'b0);
    send_word(ChTab, 1'b0);
    send_word(ChNl, 1'b0);
    send_word("Z", 1'b0);
    send_word(8'h7F, 1'b0);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h80, 1'b0);
    send_word(8'h08, 1'b0);
    send_word(8'h0B, 1'b0);
    send_word("q", 1'b1);
    send_word("x", 1'b0);
    send_word("y", 1'b0);
    drain();

    mins = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd65, 7'd2, 7'($urandom_range(3, 12)), 7'd4};
    foreach (mins[p]) begin
      write_min(mins[p]);
      idle_pct = (p == 3) ? 0 : 28;
      budget = bytes_sent + 52;
      while (bytes_sent < budget) begin
        send_run();
        if (p == 5 && bytes_sent >= budget - 30 && bytes_sent < budget - 20) drain();
      end
      drain();
    end

    in_ch.valid <= 1'b0;
    while (sb.backlog() > 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (sb.errors == 0 && sb.backlog() == 0) begin
      $display("[printable_run_extractor_top] OK");
    end else begin
      if (sb.backlog() > 0) $display("%0t: %0d words never arrived", $time, sb.backlog());
      $display("[printable_run_extractor_top] ERROR");
    end
    $finish;
  end

  initial begin : sink_side
    int hold_left;
    int seen;
    bit held_once;
    hold_left = 0;
    seen      = 0;
    held_once = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_ch.valid && out_ch.ready) begin
        sb.check_word('{out_ch.out_byte, out_ch.run_start, out_ch.last});
        seen++;
        if (seen == 40 && !held_once) begin
          hold_left = 250;
          held_once = 1'b1;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("[printable_run_extractor_top] ERROR");
    $finish;
  end

endmodule
